// ===== rtl/ebsc_pkg.sv =====
package ebsc_pkg;

    localparam int STACK_DEPTH_DEF   = 64;
    localparam int POSITION_BITS_DEF = 16;
    localparam int OUT_POS_W         = 16;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] BR_ROUND  = 2'd0;
    localparam logic [1:0] BR_SQUARE = 2'd1;
    localparam logic [1:0] BR_CURLY  = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_BAD_CHAR   = 4'd1;
    localparam logic [3:0] ERR_UNOPENED   = 4'd2;
    localparam logic [3:0] ERR_MISMATCH   = 4'd3;
    localparam logic [3:0] ERR_UNCLOSED   = 4'd4;
    localparam logic [3:0] ERR_ADJ_NUMBER = 4'd5;
    localparam logic [3:0] ERR_STRAY_OP   = 4'd6;
    localparam logic [3:0] ERR_NO_NUMBER  = 4'd7;
    localparam logic [3:0] ERR_ENDS_OP    = 4'd8;
    localparam logic [3:0] ERR_OVERFLOW   = 4'd9;

    typedef struct packed {
        logic       allowed;
        logic       digit;
        logic       op;
        logic       opening;
        logic       closing;
        logic [1:0] code;
    } class_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [1:0] code;
    } stk_cmd_t;

    typedef struct packed {
        logic       empty;
        logic       single;
        logic       full;
        logic [1:0] top;
    } stk_stat_t;

    function automatic class_t classify(input logic [7:0] ch);
        class_t c;
        logic   sp;
        c = '0;
        sp = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        c.digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        c.op = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);
        case (ch)
            CH_LPAREN: begin c.opening = 1'b1; c.code = BR_ROUND;  end
            CH_LBRACK: begin c.opening = 1'b1; c.code = BR_SQUARE; end
            CH_LBRACE: begin c.opening = 1'b1; c.code = BR_CURLY;  end
            CH_RPAREN: begin c.closing = 1'b1; c.code = BR_ROUND;  end
            CH_RBRACK: begin c.closing = 1'b1; c.code = BR_SQUARE; end
            CH_RBRACE: begin c.closing = 1'b1; c.code = BR_CURLY;  end
            default: begin end
        endcase
        c.allowed = sp || c.digit || c.op || c.opening || c.closing;
        return c;
    endfunction

endpackage

// ===== rtl/ebsc_stack.sv =====
module ebsc_stack #(
    parameter int STACK_DEPTH = ebsc_pkg::STACK_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ebsc_pkg::stk_cmd_t   cmd,
    output ebsc_pkg::stk_stat_t  stat
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [1:0]    mem [STACK_DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    top_reg, top_next;
    logic [1:0]    below_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        if (cmd.push) begin
            count_next = count_reg + CW'(1);
            top_next   = cmd.code;
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
            top_next   = below_reg;
        end
        if (cmd.clear) begin
            count_next = '0;
        end
    end

    // prefetch the entry under the next top so a pop can follow at once
    assign rd_addr = AW'(count_next - CW'(2));
    assign wr_addr = count_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_addr] <= cmd.code;
        end
        below_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        top_reg <= top_next;
    end

    assign stat.empty  = (count_reg == '0);
    assign stat.single = (count_reg == CW'(1));
    assign stat.full   = (count_reg == CW'(STACK_DEPTH));
    assign stat.top    = top_reg;

endmodule

// ===== rtl/expression_bracket_syntax_checker_core.sv =====
// Checks an arithmetic expression streamed one byte per beat (character set, bracket
// nesting, number/operator alternation) and gives one verdict beat after each beat with
// tlast set. A beat is taken every cycle unless a tlast beat waits on a held verdict;
// each character goes through an input register and then classify plus a push or pop of
// the bracket stack, whose entries sit in a small memory with the top kept in a register
// and the entry below prefetched; the verdict goes to an output register. Nesting deeper
// than STACK_DEPTH is an overflow error; positions saturate at 2^POSITION_BITS - 1.
module expression_bracket_syntax_checker_core #(
    parameter int STACK_DEPTH   = ebsc_pkg::STACK_DEPTH_DEF,
    parameter int POSITION_BITS = ebsc_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic [0:0]  s_tuser,   // [0] has_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // chars_ok, brackets_ok, structure_ok, accepted,
                                   // error_kind[3:0], error_position[15:0]
);

    localparam int PB = POSITION_BITS;
    localparam int OW = ebsc_pkg::OUT_POS_W;

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    logic             in_has_reg;
    logic             in_last_reg;

    logic [PB-1:0]    pos_reg, pos_next, pos_upd;
    logic [PB-1:0]    cerr_reg, cerr_next, cerr_upd;
    logic [3:0]       bkind_reg, bkind_next, bkind_upd;
    logic [PB-1:0]    bpos_reg, bpos_next, bpos_upd;
    logic [3:0]       skind_reg, skind_next, skind_upd;
    logic [PB-1:0]    spos_reg, spos_next, spos_upd;
    logic             expect_reg, expect_next, expect_upd;
    logic             seen_reg, seen_next, seen_upd;
    logic             prevdig_reg, prevdig_next, prevdig_upd;

    logic             m_valid_reg;
    logic [23:0]      m_data_reg;

    logic             out_free;
    logic             advance;
    logic             do_char;
    logic             finish;
    ebsc_pkg::class_t    cls;
    ebsc_pkg::stk_cmd_t  stk_cmd;
    ebsc_pkg::stk_stat_t stk_stat;
    logic             empty_after;

    logic             cok, bok, sok;
    logic [3:0]       bk_f, sk_f, kind;
    logic [PB-1:0]    bp_f, sp_f, epos;

    ebsc_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .stat    (stk_stat)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign do_char  = advance && in_has_reg;
    assign finish   = advance && in_last_reg;
    assign cls      = ebsc_pkg::classify(in_char_reg);

    always_comb begin
        pos_upd     = pos_reg;
        cerr_upd    = cerr_reg;
        bkind_upd   = bkind_reg;
        bpos_upd    = bpos_reg;
        skind_upd   = skind_reg;
        spos_upd    = spos_reg;
        expect_upd  = expect_reg;
        seen_upd    = seen_reg;
        prevdig_upd = prevdig_reg;
        stk_cmd     = '0;
        stk_cmd.code  = cls.code;
        stk_cmd.clear = finish;

        if (do_char) begin
            if (pos_reg != '1) begin
                pos_upd = pos_reg + PB'(1);
            end
            if (cerr_reg == '0 && !cls.allowed) begin
                cerr_upd = pos_upd;
            end

            if (bkind_reg == ebsc_pkg::ERR_NONE) begin
                if (cls.opening) begin
                    if (stk_stat.full) begin
                        bkind_upd = ebsc_pkg::ERR_OVERFLOW;
                        bpos_upd  = pos_upd;
                    end else begin
                        stk_cmd.push = 1'b1;
                    end
                end else if (cls.closing) begin
                    if (stk_stat.empty) begin
                        bkind_upd = ebsc_pkg::ERR_UNOPENED;
                        bpos_upd  = pos_upd;
                    end else if (stk_stat.top != cls.code) begin
                        bkind_upd = ebsc_pkg::ERR_MISMATCH;
                        bpos_upd  = pos_upd;
                    end else begin
                        stk_cmd.pop = 1'b1;
                    end
                end
            end

            if (skind_reg == ebsc_pkg::ERR_NONE) begin
                if (cls.digit) begin
                    // only the first digit of a run counts as a number
                    if (!prevdig_reg) begin
                        if (!expect_reg) begin
                            skind_upd = ebsc_pkg::ERR_ADJ_NUMBER;
                            spos_upd  = pos_upd;
                        end else begin
                            seen_upd   = 1'b1;
                            expect_upd = 1'b0;
                        end
                    end
                end else if (cls.op) begin
                    if (expect_reg) begin
                        skind_upd = ebsc_pkg::ERR_STRAY_OP;
                        spos_upd  = pos_upd;
                    end else begin
                        expect_upd = 1'b1;
                    end
                end
            end
            prevdig_upd = cls.digit;
        end

        empty_after = stk_cmd.push ? 1'b0 : (stk_cmd.pop ? stk_stat.single : stk_stat.empty);

        // end-of-text checks on the updated state
        bk_f = bkind_upd;
        bp_f = bpos_upd;
        if (bkind_upd == ebsc_pkg::ERR_NONE && !empty_after) begin
            bk_f = ebsc_pkg::ERR_UNCLOSED;
            bp_f = '0;
        end
        sk_f = skind_upd;
        sp_f = spos_upd;
        if (skind_upd == ebsc_pkg::ERR_NONE) begin
            if (!seen_upd) begin
                sk_f = ebsc_pkg::ERR_NO_NUMBER;
                sp_f = '0;
            end else if (expect_upd) begin
                sk_f = ebsc_pkg::ERR_ENDS_OP;
                sp_f = '0;
            end
        end
        cok  = (cerr_upd == '0);
        bok  = cok && (bk_f == ebsc_pkg::ERR_NONE);
        sok  = bok && (sk_f == ebsc_pkg::ERR_NONE);
        kind = ebsc_pkg::ERR_NONE;
        epos = '0;
        if (!cok) begin
            kind = ebsc_pkg::ERR_BAD_CHAR;
            epos = cerr_upd;
        end else if (!bok) begin
            kind = bk_f;
            epos = bp_f;
        end else if (!sok) begin
            kind = sk_f;
            epos = sp_f;
        end

        if (finish) begin
            pos_next     = '0;
            cerr_next    = '0;
            bkind_next   = ebsc_pkg::ERR_NONE;
            bpos_next    = '0;
            skind_next   = ebsc_pkg::ERR_NONE;
            spos_next    = '0;
            expect_next  = 1'b1;
            seen_next    = 1'b0;
            prevdig_next = 1'b0;
        end else begin
            pos_next     = pos_upd;
            cerr_next    = cerr_upd;
            bkind_next   = bkind_upd;
            bpos_next    = bpos_upd;
            skind_next   = skind_upd;
            spos_next    = spos_upd;
            expect_next  = expect_upd;
            seen_next    = seen_upd;
            prevdig_next = prevdig_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pos_reg      <= '0;
            cerr_reg     <= '0;
            bkind_reg    <= ebsc_pkg::ERR_NONE;
            bpos_reg     <= '0;
            skind_reg    <= ebsc_pkg::ERR_NONE;
            spos_reg     <= '0;
            expect_reg   <= 1'b1;
            seen_reg     <= 1'b0;
            prevdig_reg  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            pos_reg     <= pos_next;
            cerr_reg    <= cerr_next;
            bkind_reg   <= bkind_next;
            bpos_reg    <= bpos_next;
            skind_reg   <= skind_next;
            spos_reg    <= spos_next;
            expect_reg  <= expect_next;
            seen_reg    <= seen_next;
            prevdig_reg <= prevdig_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_has_reg  <= s_tuser[0];
            in_last_reg <= s_tlast;
        end
        if (finish) begin
            m_data_reg <= {OW'(epos), kind, sok, sok, bok, cok};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_flag_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((!m_tdata[2] || m_tdata[1]) && (!m_tdata[1] || m_tdata[0])))
        else $error("verdict flags out of order");

    a_kind_vs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:4] == ebsc_pkg::ERR_NONE) == m_tdata[3]))
        else $error("error kind disagrees with verdict");

    a_end_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[7:4] == ebsc_pkg::ERR_UNCLOSED ||
                      m_tdata[7:4] == ebsc_pkg::ERR_NO_NUMBER ||
                      m_tdata[7:4] == ebsc_pkg::ERR_ENDS_OP)) |-> (m_tdata[23:8] == '0))
        else $error("end-of-text error with a position");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stk_cmd.push && stk_stat.full) && !(stk_cmd.pop && stk_stat.empty))
        else $error("bracket stack overrun");
`endif

endmodule
